// ===== design/frr_pkg.sv =====
// Shared constants, status codes and inter-module structs for the frame
// reassembly receiver. No dependencies.
package frr_pkg;

    localparam int FRAME_SLOTS = 16;
    localparam int SLOT_BYTES  = 256;

    localparam int SLOT_W    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int RS_W      = $clog2(FRAME_SLOTS + 1);
    localparam int CNT_W     = RS_W;
    localparam int OFF_W     = $clog2(SLOT_BYTES);
    localparam int LEN_W     = $clog2(SLOT_BYTES + 1);
    localparam int IDX_W     = 9;
    localparam int PAY_AW    = SLOT_W + 1 + OFF_W;
    localparam int PAY_DEPTH = 1 << PAY_AW;

    localparam logic [IDX_W-1:0] IDX_MAX   = '1;
    localparam logic [7:0]       CSUM_BASE = 8'hFF;

    typedef enum logic [3:0] {
        ST_TAKEN       = 4'd0,
        ST_FRAME_OK    = 4'd1,
        ST_ID_MISMATCH = 4'd2,
        ST_BAD_CSUM    = 4'd3,
        ST_BAD_LEN     = 4'd4,
        ST_SLOT_RANGE  = 4'd5,
        ST_MSG_BYTE    = 4'd6,
        ST_INCOMPLETE  = 4'd7,
        ST_EMPTY       = 4'd8
    } status_t;

    // Payload byte written to the staging bank of a slot
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  off;
        logic [7:0]        data;
    } pay_wr_t;

    // Good frame: publish the staged bank and its length
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic              set_count;
        logic [7:0]        count;
    } commit_t;

    typedef struct packed {
        status_t status;
        logic    is_data;
        logic    last;
        logic    complete;
    } result_t;

endpackage

// ===== design/frr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled. No dependencies.
module frr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/frr_parse.sv =====
// Frame byte parser: id check, header capture, checksum and length checks,
// payload staging writes and the commit of good frames. Uses frr_pkg.
module frr_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take_byte,
    input  logic [7:0]        frame_byte,
    input  logic              end_of_frame,
    output frr_pkg::status_t  byte_status,
    output frr_pkg::commit_t  commit,
    output frr_pkg::pay_wr_t  pay_wr
);
    import frr_pkg::*;

    logic [7:0]       latched_id_reg, latched_id_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       frame_num_reg, frame_num_next;
    logic [7:0]       pending_count_reg, pending_count_next;
    logic             id_failed_reg, id_failed_next;

    logic [IDX_W-1:0] hdr_len;
    logic [IDX_W-1:0] pay_off;
    logic             slot_ok;

    assign hdr_len = (frame_num_reg == 8'd0) ? IDX_W'(3) : IDX_W'(2);
    assign pay_off = byte_index_reg - hdr_len;
    assign slot_ok = {1'b0, frame_num_reg} < 9'(FRAME_SLOTS);

    always_comb begin
        latched_id_next    = latched_id_reg;
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg;
        frame_num_next     = frame_num_reg;
        pending_count_next = pending_count_reg;
        id_failed_next     = id_failed_reg;
        byte_status        = ST_TAKEN;
        commit             = '0;
        pay_wr             = '0;

        commit.slot      = frame_num_reg[SLOT_W-1:0];
        commit.len       = pay_off[LEN_W-1:0];
        commit.set_count = (frame_num_reg == 8'd0);
        commit.count     = pending_count_reg;

        if (take_byte && !end_of_frame) begin
            if (byte_index_reg == '0) begin
                if (latched_id_reg == 8'd0) begin
                    latched_id_next = frame_byte;
                end else if (latched_id_reg != frame_byte) begin
                    id_failed_next = 1'b1;
                end
            end else begin
                running_sum_next = running_sum_reg + frame_byte;
                if (byte_index_reg == IDX_W'(1)) begin
                    frame_num_next = frame_byte;
                end else if (byte_index_reg == IDX_W'(2) && frame_num_reg == 8'd0) begin
                    pending_count_next = frame_byte;
                end else if (pay_off < IDX_W'(SLOT_BYTES) && slot_ok) begin
                    // stage into the bank readers do not see
                    pay_wr.en   = 1'b1;
                    pay_wr.slot = frame_num_reg[SLOT_W-1:0];
                    pay_wr.off  = pay_off[OFF_W-1:0];
                    pay_wr.data = frame_byte;
                end
            end
            if (byte_index_reg != IDX_MAX) begin
                byte_index_next = byte_index_reg + IDX_W'(1);
            end
        end else if (take_byte) begin
            if (id_failed_reg) begin
                byte_status = ST_ID_MISMATCH;
            end else if (byte_index_reg < hdr_len || pay_off > IDX_W'(SLOT_BYTES)) begin
                byte_status = ST_BAD_LEN;
            end else if (CSUM_BASE - running_sum_reg != frame_byte) begin
                byte_status = ST_BAD_CSUM;
            end else if (!slot_ok) begin
                byte_status = ST_SLOT_RANGE;
            end else begin
                byte_status = ST_FRAME_OK;
                commit.en   = 1'b1;
            end
            byte_index_next    = '0;
            running_sum_next   = '0;
            frame_num_next     = '0;
            pending_count_next = '0;
            id_failed_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_id_reg    <= '0;
            byte_index_reg    <= '0;
            running_sum_reg   <= '0;
            frame_num_reg     <= '0;
            pending_count_reg <= '0;
            id_failed_reg     <= 1'b0;
        end else begin
            latched_id_reg    <= latched_id_next;
            byte_index_reg    <= byte_index_next;
            running_sum_reg   <= running_sum_next;
            frame_num_reg     <= frame_num_next;
            pending_count_reg <= pending_count_next;
            id_failed_reg     <= id_failed_next;
        end
    end

endmodule

// ===== design/frr_slots.sv =====
// Slot table and read pointer: valid/bank/length per slot, frame count,
// next-slot priority search and payload RAM addressing. Uses frr_pkg.
module frr_slots (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      take_read,
    input  frr_pkg::commit_t          commit,
    input  frr_pkg::pay_wr_t          pay_wr,
    output logic                      ram_we,
    output logic [frr_pkg::PAY_AW-1:0] ram_waddr,
    output logic [7:0]                ram_wdata,
    output logic                      ram_re,
    output logic [frr_pkg::PAY_AW-1:0] ram_raddr,
    output frr_pkg::status_t          rd_status,
    output logic                      rd_is_data,
    output logic                      rd_last,
    output logic                      complete_next
);
    import frr_pkg::*;

    logic [FRAME_SLOTS-1:0] valid_reg, valid_next;
    logic [FRAME_SLOTS-1:0] bank_reg, bank_next;
    logic [LEN_W-1:0]       len_reg [FRAME_SLOTS];
    logic [7:0]             expected_reg, expected_next;
    logic [CNT_W-1:0]       valid_cnt_reg, valid_cnt_next;
    logic [RS_W-1:0]        read_slot_reg, read_slot_next;
    logic [OFF_W-1:0]       read_off_reg, read_off_next;

    logic [FRAME_SLOTS-1:0] nonempty;
    logic [FRAME_SLOTS-1:0] multi;
    logic [FRAME_SLOTS-1:0] cand;
    logic [FRAME_SLOTS-1:0] later;
    logic                   complete_now;
    logic                   rs_in;
    logic [SLOT_W-1:0]      rs_idx;
    logic                   start_hit;
    logic                   found;
    logic [SLOT_W-1:0]      hit_slot;
    logic                   hit_is_start;
    logic [OFF_W-1:0]       off_used;
    logic                   stay;

    assign complete_now = (expected_reg != 8'd0) &&
                          (10'(expected_reg) == 10'(valid_cnt_reg));
    assign rs_in        = read_slot_reg < RS_W'(FRAME_SLOTS);
    assign rs_idx       = read_slot_reg[SLOT_W-1:0];
    assign start_hit    = rs_in && valid_reg[rs_idx] &&
                          (len_reg[rs_idx] > LEN_W'(read_off_reg));

    always_comb begin
        for (int s = 0; s < FRAME_SLOTS; s++) begin
            nonempty[s] = valid_reg[s] && (len_reg[s] != '0);
            multi[s]    = valid_reg[s] && (len_reg[s] > LEN_W'(1));
            if (RS_W'(s) == read_slot_reg) begin
                cand[s] = start_hit;
            end else begin
                cand[s] = (RS_W'(s) > read_slot_reg) && nonempty[s];
            end
        end
    end

    // lowest candidate slot at or after the read pointer
    always_comb begin
        found    = 1'b0;
        hit_slot = '0;
        for (int s = FRAME_SLOTS - 1; s >= 0; s--) begin
            if (cand[s]) begin
                found    = 1'b1;
                hit_slot = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        for (int s = 0; s < FRAME_SLOTS; s++) begin
            later[s] = nonempty[s] && (SLOT_W'(s) > hit_slot);
        end
    end

    assign hit_is_start = RS_W'(hit_slot) == read_slot_reg;
    assign off_used     = hit_is_start ? read_off_reg : '0;
    assign stay         = hit_is_start ?
                          (LEN_W'(read_off_reg) + LEN_W'(1) < len_reg[rs_idx]) :
                          multi[hit_slot];

    assign ram_we    = pay_wr.en;
    assign ram_waddr = {pay_wr.slot, ~bank_reg[pay_wr.slot], pay_wr.off};
    assign ram_wdata = pay_wr.data;

    always_comb begin
        valid_next     = valid_reg;
        bank_next      = bank_reg;
        expected_next  = expected_reg;
        valid_cnt_next = valid_cnt_reg;
        read_slot_next = read_slot_reg;
        read_off_next  = read_off_reg;
        ram_re         = 1'b0;
        ram_raddr      = {hit_slot, bank_reg[hit_slot], off_used};
        rd_status      = ST_INCOMPLETE;
        rd_is_data     = 1'b0;
        rd_last        = 1'b0;

        if (commit.en) begin
            valid_next[commit.slot] = 1'b1;
            bank_next[commit.slot]  = ~bank_reg[commit.slot];
            if (!valid_reg[commit.slot]) begin
                valid_cnt_next = valid_cnt_reg + CNT_W'(1);
            end
            if (commit.set_count) begin
                expected_next = commit.count;
            end
        end

        if (take_read && complete_now) begin
            if (found) begin
                ram_re     = 1'b1;
                rd_status  = ST_MSG_BYTE;
                rd_is_data = 1'b1;
                if (stay) begin
                    read_slot_next = RS_W'(hit_slot);
                    read_off_next  = off_used + OFF_W'(1);
                end else begin
                    read_slot_next = RS_W'(hit_slot) + RS_W'(1);
                    read_off_next  = '0;
                    rd_last        = ~|later;
                end
            end else begin
                rd_status = ST_EMPTY;
                rd_last   = 1'b1;
            end
            // drop the message after its final byte, or on a read that finds no byte
            if (rd_last) begin
                valid_next     = '0;
                valid_cnt_next = '0;
                read_slot_next = '0;
                read_off_next  = '0;
            end
        end

        complete_next = (expected_next != 8'd0) &&
                        (10'(expected_next) == 10'(valid_cnt_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            bank_reg      <= '0;
            expected_reg  <= '0;
            valid_cnt_reg <= '0;
            read_slot_reg <= '0;
            read_off_reg  <= '0;
        end else begin
            valid_reg     <= valid_next;
            bank_reg      <= bank_next;
            expected_reg  <= expected_next;
            valid_cnt_reg <= valid_cnt_next;
            read_slot_reg <= read_slot_next;
            read_off_reg  <= read_off_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit.en) begin
            len_reg[commit.slot] <= commit.len;
        end
    end

endmodule

// ===== design/frr_out.sv =====
// Result pipeline: one stage aligned with the payload RAM read, then an
// output register toward the result channel. Uses frr_pkg.
module frr_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  frr_pkg::result_t  in_res,
    input  logic [7:0]        ram_rdata,
    output logic              in_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_status,
    output logic [7:0]        m_data_byte,
    output logic              m_last_byte,
    output logic              m_message_complete
);
    import frr_pkg::*;

    logic    p1_valid_reg, p1_valid_next;
    result_t p1_res_reg;
    logic    out_valid_reg, out_valid_next;
    logic [3:0] out_status_reg;
    logic [7:0] out_data_reg;
    logic    out_last_reg;
    logic    out_complete_reg;
    logic    p1_move;

    // advance the RAM-aligned stage whenever the output slot frees up
    assign p1_move  = p1_valid_reg && (!out_valid_reg || m_ready);
    assign in_ready = !p1_valid_reg || p1_move;

    always_comb begin
        p1_valid_next  = p1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_valid) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
        if (p1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            p1_res_reg <= in_res;
        end
        if (p1_move) begin
            out_status_reg   <= p1_res_reg.status;
            out_data_reg     <= p1_res_reg.is_data ? ram_rdata : 8'd0;
            out_last_reg     <= p1_res_reg.last;
            out_complete_reg <= p1_res_reg.complete;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_status_reg;
    assign m_data_byte        = out_data_reg;
    assign m_last_byte        = out_last_reg;
    assign m_message_complete = out_complete_reg;

endmodule

// ===== design/frame_reassembly_receiver.sv =====
// Top level of the frame reassembly receiver: parser, slot table, payload
// RAM and result pipeline. Uses frr_pkg, frr_ram, frr_parse, frr_slots, frr_out.
//
// Usage:
//   Input channel (s_valid/s_ready): one transfer per frame byte
//   (s_action = 0, s_end_of_frame marks the checksum byte) or per message
//   read request (s_action = 1). Every input transfer yields exactly one
//   result transfer on the m_ channel, in order.
//   Throughput: one transfer per cycle while s_ready is high, bytes and
//   reads mixed freely; the parser and slot table update in the cycle of
//   acceptance, and the payload RAM's single write and single read port
//   serve one item each cycle. A result reaches m_ through the registered
//   payload RAM read stage and then the output register.
//   Payload is staged in the hidden bank of the target slot and published
//   by flipping that slot's bank bit when the frame passes its checks.
//   Stall: while m_ready is low the output register holds; one more result
//   waits in the RAM stage, after which s_ready drops until the output drains.
//   Reset (aresetn low, synchronous): clears the latched id, frame parser,
//   frame count, slot valid bits and read pointer; no clearing pass is needed.
module frame_reassembly_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_frame_byte,
    input  logic       s_end_of_frame,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_status,
    output logic [7:0] m_data_byte,
    output logic       m_last_byte,
    output logic       m_message_complete
);
    import frr_pkg::*;

    logic              accept;
    logic              take_byte;
    logic              take_read;
    status_t           byte_status;
    commit_t           commit;
    pay_wr_t           pay_wr;
    logic              ram_we;
    logic [PAY_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [PAY_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    status_t           rd_status;
    logic              rd_is_data;
    logic              rd_last;
    logic              complete_next;
    result_t           res;

    assign accept    = s_valid && s_ready;
    assign take_byte = accept && !s_action;
    assign take_read = accept && s_action;

    frr_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take_byte    (take_byte),
        .frame_byte   (s_frame_byte),
        .end_of_frame (s_end_of_frame),
        .byte_status  (byte_status),
        .commit       (commit),
        .pay_wr       (pay_wr)
    );

    frr_slots u_slots (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take_read     (take_read),
        .commit        (commit),
        .pay_wr        (pay_wr),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .rd_status     (rd_status),
        .rd_is_data    (rd_is_data),
        .rd_last       (rd_last),
        .complete_next (complete_next)
    );

    frr_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        res.status   = s_action ? rd_status : byte_status;
        res.is_data  = s_action && rd_is_data;
        res.last     = s_action && rd_last;
        res.complete = complete_next;
    end

    frr_out u_out (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (accept),
        .in_res             (res),
        .ram_rdata          (ram_rdata),
        .in_ready           (s_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_data_byte        (m_data_byte),
        .m_last_byte        (m_last_byte),
        .m_message_complete (m_message_complete)
    );

endmodule

// ===== design/frr_checker.sv =====
// Port-level checks for the frame reassembly receiver, bound to the top
// level. Uses frr_pkg.
module frr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_status,
    input logic [7:0] m_data_byte,
    input logic       m_last_byte,
    input logic       m_message_complete
);
    import frr_pkg::*;

    // data is only carried by message byte results
    a_data_only_on_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_MSG_BYTE) |-> m_data_byte == 8'd0)
        else $error("nonzero data byte on a non-message result");

    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> (m_status == ST_MSG_BYTE) || (m_status == ST_EMPTY))
        else $error("last byte flag on a result that ends no message");

    // the message is dropped after its last byte
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> !m_message_complete)
        else $error("message still complete after its last byte");

    a_incomplete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_INCOMPLETE) |-> !m_message_complete)
        else $error("incomplete read reports a complete message");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_byte))
        else $error("result changed while stalled");

endmodule

bind frame_reassembly_receiver frr_checker u_frr_checker (.*);
